/* rtl/hbu_pkg.sv */
// shared types and constants of the horizontal blur and upscale block
`default_nettype none

package hbu_pkg;

    localparam int PIX_W    = 32;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = PIX_W / CHAN_W;
    localparam int STR_W    = 9;
    localparam int SIDE_W   = 7;
    localparam int MID_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    localparam logic [STR_W-1:0] FULL_WEIGHT = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_BLUR_STRENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIDTH  = 1'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             line_end;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             line_done;
    } out_item_t;

    // one filter job: the outputs of one source pixel
    typedef struct packed {
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  centre;
        logic [PIX_W-1:0]  right;
        logic [SIDE_W-1:0] w_side;
        logic [MID_W-1:0]  w_mid;
        logic              dbl;
        logic              last;
    } job_t;

endpackage

`default_nettype wire

/* rtl/hbu_front.sv */
// front end: configuration, neighbor tracking and job building
`default_nettype none

module hbu_front
    import hbu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_DAT_W-1:0] wr_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_item_t             source,
    output logic                      q_wr_valid,
    output job_t                      q_wr_data,
    input  wire logic                 q_full
);

    logic [STR_W-1:0] strength_reg;
    logic             double_reg;
    logic [PIX_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] centre_reg, centre_next;
    logic             have_reg, have_next;
    job_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;

    logic [STR_W-1:0] s_clamp;
    logic [SIDE_W-1:0] w_side;
    logic [MID_W-1:0]  w_mid;
    logic              accept;
    job_t              job_now;
    job_t              job_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= '0;
            double_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BLUR_STRENGTH: strength_reg <= wr_data[STR_W-1:0];
                REG_DOUBLE_WIDTH:  double_reg   <= wr_data[0];
                default: ;
            endcase
        end
    end

    // weights for the mode in force
    always_comb
    begin
        s_clamp = (strength_reg > FULL_WEIGHT) ? FULL_WEIGHT : strength_reg;
        w_side  = s_clamp[STR_W-1:2];
        if (double_reg)
            w_mid = FULL_WEIGHT - {2'b00, w_side};
        else
            w_mid = FULL_WEIGHT - {1'b0, s_clamp[STR_W-1:1]};
    end

    assign full   = pend_valid_reg || q_full;
    assign accept = push && !full;

    always_comb
    begin
        job_now = '0;
        job_end = '0;
        job_now.dbl = double_reg;
        job_end.dbl = double_reg;
        if (!have_reg)
        begin
            // lone pixel line: plain copy
            job_now.left   = source.pixel_in;
            job_now.centre = source.pixel_in;
            job_now.right  = source.pixel_in;
            job_now.w_side = '0;
            job_now.w_mid  = FULL_WEIGHT;
            job_now.last   = 1'b1;
        end
        else
        begin
            job_now.left   = left_reg;
            job_now.centre = centre_reg;
            job_now.right  = source.pixel_in;
            job_now.w_side = w_side;
            job_now.w_mid  = w_mid;
            job_now.last   = 1'b0;
        end
        job_end.left   = centre_reg;
        job_end.centre = source.pixel_in;
        job_end.right  = source.pixel_in;
        job_end.w_side = w_side;
        job_end.w_mid  = w_mid;
        job_end.last   = 1'b1;
    end

    always_comb
    begin
        q_wr_valid      = 1'b0;
        q_wr_data       = job_now;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        left_next       = left_reg;
        centre_next     = centre_reg;
        have_next       = have_reg;
        if (pend_valid_reg)
        begin
            q_wr_valid = 1'b1;
            q_wr_data  = pend_reg;
            if (!q_full)
                pend_valid_next = 1'b0;
        end
        else if (accept)
        begin
            q_wr_valid = have_reg || source.line_end;
            if (have_reg)
            begin
                left_next   = centre_reg;
                centre_next = source.pixel_in;
                if (source.line_end)
                begin
                    pend_next       = job_end;
                    pend_valid_next = 1'b1;
                    left_next       = '0;
                    centre_next     = '0;
                    have_next       = 1'b0;
                end
            end
            else if (!source.line_end)
            begin
                left_next   = source.pixel_in;
                centre_next = source.pixel_in;
                have_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            centre_reg     <= '0;
            have_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg       <= left_next;
            centre_reg     <= centre_next;
            have_reg       <= have_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

/* rtl/hbu_queue.sv */
// two-entry job queue between front and back
`default_nettype none

module hbu_queue
    import hbu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    input  wire job_t wr_data,
    output logic      q_full,
    output logic      rd_valid,
    output job_t      rd_data,
    input  wire logic rd_pop
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full   = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !q_full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* rtl/hbu_back.sv */
// back end: per-channel weighted sums and the result register
`default_nettype none

module hbu_back
    import hbu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rd_valid,
    input  wire job_t rd_data,
    output logic      rd_pop,
    output logic      empty,
    input  wire logic pop,
    output out_item_t result
);

    logic      half_reg, half_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    logic [PIX_W-1:0] tap_a;
    logic [PIX_W-1:0] tap_b;
    logic             final_out;
    logic             step;
    logic [PIX_W-1:0] mixed;

    function automatic logic [PIX_W-1:0] mix(
        input logic [PIX_W-1:0]  a,
        input logic [PIX_W-1:0]  c,
        input logic [PIX_W-1:0]  b,
        input logic [SIDE_W-1:0] ws,
        input logic [MID_W-1:0]  wm
    );
        logic [PIX_W-1:0] res;
        logic [16:0]      sum;
        res = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            sum = {10'b0, ws} * {9'b0, a[i*CHAN_W +: CHAN_W]}
                + {8'b0, wm} * {9'b0, c[i*CHAN_W +: CHAN_W]}
                + {10'b0, ws} * {9'b0, b[i*CHAN_W +: CHAN_W]};
            res[i*CHAN_W +: CHAN_W] = sum[15:8];
        end
        return res;
    endfunction

    always_comb
    begin
        if (rd_data.dbl)
        begin
            tap_a     = half_reg ? rd_data.right : rd_data.left;
            tap_b     = '0;
            final_out = half_reg;
        end
        else
        begin
            tap_a     = rd_data.left;
            tap_b     = rd_data.right;
            final_out = 1'b1;
        end
        mixed = mix(tap_a, rd_data.centre, tap_b, rd_data.w_side, rd_data.w_mid);
    end

    assign step   = rd_valid && (!out_valid_reg || pop);
    assign rd_pop = step && final_out;
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            half_next      = !final_out;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg.pixel_out <= mixed;
            out_reg.line_done <= rd_data.last && final_out;
        end
    end

endmodule

`default_nettype wire

/* rtl/horizontal_blur_upscale.sv */
// top level of the horizontal blur filter with optional 2x upscale
//
// source side: a queue-style input; a source pixel and its line_end flag
//   transfer on a rising edge with push high and full low
// result side: the oldest result sits on result while empty is low and
//   transfers on a rising edge with pop high
// configuration: wr_en / wr_index / wr_data, taken on any edge with wr_en
//   high; index 0 is blur_strength, index 1 is double_width
// path: a result's job, queued after its right neighbor or the line end is
//   taken, goes from the job queue to the back end's result register
// throughput: one result per cycle while pop keeps up, set by the single
//   mixing unit in the back end; doubling mode takes one source pixel per two
//   results, same-width mode one per cycle, and a line end adds one extra job
// a front end tracks neighbors and builds jobs, a two-entry job queue
//   separates it from the back end, which evaluates four channels at once
// reset: no pixel held, strength zero, doubling mode on, all queues empty
// stall: when pop stays low the result register holds, the job queue fills
//   and full rises; nothing is dropped
`default_nettype none

module horizontal_blur_upscale
    import hbu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_DAT_W-1:0] wr_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_item_t             source,
    output logic                      empty,
    input  wire logic                 pop,
    output out_item_t                 result
);

    // front to queue transfer
    logic q_wr_valid;
    job_t q_wr_data;
    logic q_full;

    // queue to back transfer
    logic q_rd_valid;
    job_t q_rd_data;
    logic q_rd_pop;

    hbu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .push       (push),
        .full       (full),
        .source     (source),
        .q_wr_valid (q_wr_valid),
        .q_wr_data  (q_wr_data),
        .q_full     (q_full)
    );

    hbu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_data  (q_wr_data),
        .q_full   (q_full),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .rd_pop   (q_rd_pop)
    );

    hbu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .rd_pop   (q_rd_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire
